@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
		else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
		else $error("assertion failed");

`endif

@@ hdl/erq_pkg.sv @@
// shared types, constants and tables for the euler to quaternion pipeline
`timescale 1ns / 1ps

package erq_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES  = 24;
	localparam int CORDIC_ITERS  = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

	localparam int ANGLE_W = 16;
	localparam int OUT_W   = 16;
	localparam int TRIG_W  = 32;
	localparam int CS_W    = 34;
	localparam int PROD_W  = 2 * TRIG_W;

	localparam int CONV_STAGES = 5;
	localparam int SC_LATENCY  = CONV_STAGES + CORDIC_ITERS + 1;
	localparam int PIPE_DEPTH  = SC_LATENCY + 5;

	localparam logic [15:0] RECIP45_HI = 16'd46603;
	localparam logic [26:0] RECIP45_LO = 27'd95443717;
	localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;
	typedef logic signed [CS_W-1:0]    cs_t;
	typedef logic signed [OUT_W-1:0]   quat_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051D;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2E;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2F9;
			5'd15:   r = 32'h0000517C;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A2F;
			5'd19:   r = 32'h00000517;
			5'd20:   r = 32'h0000028B;
			5'd21:   r = 32'h00000145;
			5'd22:   r = 32'h000000A2;
			5'd23:   r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/euler_rpy_to_quaternion.sv @@
// roll, pitch, yaw to quaternion: top level with product and output stages
// Usage:
//   input channel in_valid/in_ready carries roll_angle, pitch_angle and yaw_angle,
//   signed, 1/128 degree per lsb; any 16-bit value is taken
//   output channel out_valid/out_ready carries quat_w/x/y/z, Q1.15, saturated
// Pipeline from accept to out_valid:
//   half-angle conversion stages, 16 cordic iterations, 1 unfold,
//   4 multiply and round stages, 1 output register
// Throughput: one item per cycle when not stalled; every stage is a register slice
//   of the three cordic rotators or the multiplier bank, all stepping together
// Stall: while out_valid is high and out_ready low the whole pipeline holds,
//   in_ready is low, and no item is lost or repeated; bubbles are not squeezed
// Reset: arst_n clears the valid bits, so the pipeline comes up empty and
//   in_ready is high
`timescale 1ns / 1ps

module euler_rpy_to_quaternion (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  erq_pkg::angle_t roll_angle,
	input  erq_pkg::angle_t pitch_angle,
	input  erq_pkg::angle_t yaw_angle,
	output logic            out_valid,
	input  logic            out_ready,
	output erq_pkg::quat_t  quat_w,
	output erq_pkg::quat_t  quat_x,
	output erq_pkg::quat_t  quat_y,
	output erq_pkg::quat_t  quat_z
);

	localparam int D = erq_pkg::PIPE_DEPTH;

	function automatic erq_pkg::trig_t round_q30(input logic signed [erq_pkg::PROD_W-1:0] v);
		logic signed [erq_pkg::PROD_W-1:0] t;
		t = v + (erq_pkg::PROD_W'(1) <<< 29);
		return erq_pkg::TRIG_W'(t >>> 30);
	endfunction

	function automatic erq_pkg::quat_t to_q15(input erq_pkg::cs_t v);
		logic signed [erq_pkg::CS_W:0] t;
		logic signed [erq_pkg::CS_W:0] r;
		t = (erq_pkg::CS_W+1)'(v) + (erq_pkg::CS_W+1)'(1 << 14);
		r = t >>> 15;
		if (r > 32767)
			return 16'sh7FFF;
		else if (r < -32768)
			return 16'sh8000;
		return erq_pkg::OUT_W'(r);
	endfunction

	logic adv;
	logic vld_q [D];

	assign adv       = !vld_q[D-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < D; k++)
				vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < D; k++)
				vld_q[k] <= vld_q[k-1];
		end
	end

	erq_pkg::trig_t sr, cr, sp, cp, sy, cy;

	erq_sincos u_roll  (.clk(clk), .en(adv), .angle(roll_angle),  .sin_val(sr), .cos_val(cr));
	erq_sincos u_pitch (.clk(clk), .en(adv), .angle(pitch_angle), .sin_val(sp), .cos_val(cp));
	erq_sincos u_yaw   (.clk(clk), .en(adv), .angle(yaw_angle),   .sin_val(sy), .cos_val(cy));

	// first products
	logic signed [erq_pkg::PROD_W-1:0] crcy_s1, srsy_s1, srcy_s1, crsy_s1;
	erq_pkg::trig_t cp_s1, sp_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			crcy_s1 <= erq_pkg::PROD_W'(cr) * erq_pkg::PROD_W'(cy);
			srsy_s1 <= erq_pkg::PROD_W'(sr) * erq_pkg::PROD_W'(sy);
			srcy_s1 <= erq_pkg::PROD_W'(sr) * erq_pkg::PROD_W'(cy);
			crsy_s1 <= erq_pkg::PROD_W'(cr) * erq_pkg::PROD_W'(sy);
			cp_s1   <= cp;
			sp_s1   <= sp;
		end
	end

	// round to Q2.30
	erq_pkg::trig_t crcy_s2, srsy_s2, srcy_s2, crsy_s2, cp_s2, sp_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			crcy_s2 <= round_q30(crcy_s1);
			srsy_s2 <= round_q30(srsy_s1);
			srcy_s2 <= round_q30(srcy_s1);
			crsy_s2 <= round_q30(crsy_s1);
			cp_s2   <= cp_s1;
			sp_s2   <= sp_s1;
		end
	end

	// second products
	logic signed [erq_pkg::PROD_W-1:0] w0_s3, w1_s3, x0_s3, x1_s3;
	logic signed [erq_pkg::PROD_W-1:0] y0_s3, y1_s3, z0_s3, z1_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			w0_s3 <= erq_pkg::PROD_W'(crcy_s2) * erq_pkg::PROD_W'(cp_s2);
			w1_s3 <= erq_pkg::PROD_W'(srsy_s2) * erq_pkg::PROD_W'(sp_s2);
			x0_s3 <= erq_pkg::PROD_W'(srcy_s2) * erq_pkg::PROD_W'(cp_s2);
			x1_s3 <= erq_pkg::PROD_W'(crsy_s2) * erq_pkg::PROD_W'(sp_s2);
			y0_s3 <= erq_pkg::PROD_W'(crsy_s2) * erq_pkg::PROD_W'(cp_s2);
			y1_s3 <= erq_pkg::PROD_W'(srcy_s2) * erq_pkg::PROD_W'(sp_s2);
			z0_s3 <= erq_pkg::PROD_W'(crcy_s2) * erq_pkg::PROD_W'(sp_s2);
			z1_s3 <= erq_pkg::PROD_W'(srsy_s2) * erq_pkg::PROD_W'(cp_s2);
		end
	end

	// round and combine
	erq_pkg::cs_t w_s4, x_s4, y_s4, z_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s4 <= erq_pkg::CS_W'(round_q30(w0_s3)) + erq_pkg::CS_W'(round_q30(w1_s3));
			x_s4 <= erq_pkg::CS_W'(round_q30(x0_s3)) - erq_pkg::CS_W'(round_q30(x1_s3));
			y_s4 <= erq_pkg::CS_W'(round_q30(y0_s3)) + erq_pkg::CS_W'(round_q30(y1_s3));
			z_s4 <= erq_pkg::CS_W'(round_q30(z0_s3)) - erq_pkg::CS_W'(round_q30(z1_s3));
		end
	end

	// Q1.15 output register
	erq_pkg::quat_t w_q, x_q, y_q, z_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			w_q <= to_q15(w_s4);
			x_q <= to_q15(x_s4);
			y_q <= to_q15(y_s4);
			z_q <= to_q15(z_s4);
		end
	end

	assign quat_w = w_q;
	assign quat_x = x_q;
	assign quat_y = y_q;
	assign quat_z = z_q;

endmodule

@@ hdl/erq_sincos.sv @@
// half-angle conversion and pipelined cordic sine and cosine for one angle
`timescale 1ns / 1ps

module erq_sincos (
	input  logic            clk,
	input  logic            en,
	input  erq_pkg::angle_t angle,
	output erq_pkg::trig_t  sin_val,
	output erq_pkg::trig_t  cos_val
);

	localparam int N = erq_pkg::CORDIC_ITERS;

	// magnitude and coarse quotient by 45
	logic        neg_a;
	logic [15:0] mag;
	logic [31:0] dprod;
	logic [15:0] mag_s1;
	logic [10:0] dest_s1;
	logic        neg_s1;

	assign neg_a = angle[15];
	assign mag   = neg_a ? 16'(-angle) : 16'(angle);
	assign dprod = 32'(mag) * 32'(erq_pkg::RECIP45_HI);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag;
			dest_s1 <= dprod[31:21];
			neg_s1  <= neg_a;
		end
	end

	// quotient correction, remainder scaled
	logic [16:0] rem1;
	logic        rem1_ovf;
	logic [5:0]  r2;
	logic [10:0] quo_s2;
	logic [26:0] t_s2;
	logic        neg_s2;

	assign rem1     = {1'b0, mag_s1} - 17'(17'(dest_s1) * 17'd45);
	assign rem1_ovf = rem1 >= 17'd45;
	assign r2       = rem1_ovf ? 6'(rem1 - 17'd45) : 6'(rem1);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s2 <= dest_s1 + 11'(rem1_ovf);
			t_s2   <= {r2, 21'd0} + 27'd22;
			neg_s2 <= neg_s1;
		end
	end

	// fine quotient estimate
	logic [53:0] eprod;
	logic [10:0] quo_s3;
	logic [26:0] t_s3;
	logic [20:0] eest_s3;
	logic        neg_s3;

	assign eprod = 54'(t_s2) * 54'(erq_pkg::RECIP45_LO);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s3  <= quo_s2;
			t_s3    <= t_s2;
			eest_s3 <= eprod[52:32];
			neg_s3  <= neg_s2;
		end
	end

	// fine correction and binary angle magnitude
	logic [26:0] rem2;
	logic [31:0] q_s4;
	logic        neg_s4;

	assign rem2 = t_s3 - 27'(27'(eest_s3) * 27'd45);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s4   <= {quo_s3, 21'd0} + 32'(eest_s3) + 32'(rem2 >= 27'd45);
			neg_s4 <= neg_s3;
		end
	end

	// sign and fold into the right half plane
	logic [31:0]     p;
	logic            fold;
	erq_pkg::cs_t    z_s5;
	logic            flip_s5;

	assign p    = neg_s4 ? 32'(-q_s4) : q_s4;
	assign fold = p[31] ^ p[30];

	always_ff @(posedge clk) begin
		if (en) begin
			z_s5    <= erq_pkg::CS_W'($signed({p[31] ^ fold, p[30:0]}));
			flip_s5 <= fold;
		end
	end

	// cordic rotation, one iteration per stage
	erq_pkg::cs_t cx_s [N+1];
	erq_pkg::cs_t cy_s [N+1];
	erq_pkg::cs_t cz_s [N+1];
	logic         flip_s [N+1];

	assign cx_s[0]   = erq_pkg::CORDIC_GAIN;
	assign cy_s[0]   = '0;
	assign cz_s[0]   = z_s5;
	assign flip_s[0] = flip_s5;

	for (genvar i = 0; i < N; i++) begin : g_iter
		erq_pkg::cs_t atan_v;
		assign atan_v = erq_pkg::CS_W'($signed({2'b00, erq_pkg::atan_turn(5'(i))}));
		always_ff @(posedge clk) begin
			if (en) begin
				if (cz_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - atan_v;
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + atan_v;
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	// undo the fold
	erq_pkg::trig_t sin_sc;
	erq_pkg::trig_t cos_sc;

	always_ff @(posedge clk) begin
		if (en) begin
			cos_sc <= erq_pkg::TRIG_W'(flip_s[N] ? -cx_s[N] : cx_s[N]);
			sin_sc <= erq_pkg::TRIG_W'(flip_s[N] ? -cy_s[N] : cy_s[N]);
		end
	end

	assign sin_val = sin_sc;
	assign cos_val = cos_sc;

endmodule

@@ hdl/erq_checker.sv @@
// port-level checks for the euler to quaternion block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module erq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input erq_pkg::quat_t quat_w,
	input erq_pkg::quat_t quat_x,
	input erq_pkg::quat_t quat_y,
	input erq_pkg::quat_t quat_z
);

	// a stalled item stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// pipeline takes items whenever nothing waits at the output
	`ASSERT_IMPLY(a_ready_empty, clk, arst_n, !out_valid || out_ready, in_ready)
	// a stalled output freezes the input side
	`ASSERT_IMPLY(a_stall_blocks, clk, arst_n, out_valid && !out_ready, !in_ready)
	// the held item keeps its value
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable({quat_w, quat_x, quat_y, quat_z}))

endmodule

bind euler_rpy_to_quaternion erq_checker u_erq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.quat_w    (quat_w),
	.quat_x    (quat_x),
	.quat_y    (quat_y),
	.quat_z    (quat_z)
);

@@ test/euler_rpy_to_quaternion_tb.sv @@
// testbench for the roll, pitch, yaw to quaternion pipeline
`timescale 1ns / 1ps

module euler_rpy_to_quaternion_tb;

	localparam int IDLE_LIMIT = 2000;
	localparam int ITERS = (erq_pkg::CORDIC_STAGES > 24) ? 24 : erq_pkg::CORDIC_STAGES;

	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_s;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	erq_pkg::angle_t roll_angle;
	erq_pkg::angle_t pitch_angle;
	erq_pkg::angle_t yaw_angle;
	logic out_valid;
	logic out_ready;
	erq_pkg::quat_t quat_w;
	erq_pkg::quat_t quat_x;
	erq_pkg::quat_t quat_y;
	erq_pkg::quat_t quat_z;

	quat_s expected_quats[$];
	int errors;
	int idle_cycles = 0;
	bit gaps_on;

	logic [31:0] atan_lut[24] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	euler_rpy_to_quaternion uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// sine and cosine of the half angle, Q2.30
	task automatic half_sin_cos(input logic signed [15:0] ang, output longint s,
		output longint c);
		longint n, q, x, y, z, dx, dy;
		logic [31:0] p;
		bit flip;
		n = longint'(ang) * 2097152;
		q = (n >= 0) ? (n + 22) / 45 : (n - 22) / 45;
		p = q[31:0];
		flip = (p[31:30] == 2'd1) || (p[31:30] == 2'd2);
		if (flip)
			p = p + 32'h80000000;
		z = longint'($signed(p));
		x = 652032874;
		y = 0;
		for (int i = 0; i < ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(atan_lut[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(atan_lut[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint mul_q30(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic logic signed [15:0] round_q15(longint v);
		longint r;
		r = (v + 16384) >>> 15;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	task automatic predict_quat(input logic signed [15:0] r, input logic signed [15:0] p,
		input logic signed [15:0] yw);
		longint sr, cr, sp, cp, sy, cy;
		quat_s q;
		half_sin_cos(r, sr, cr);
		half_sin_cos(p, sp, cp);
		half_sin_cos(yw, sy, cy);
		q.w = round_q15(mul_q30(mul_q30(cr, cy), cp) + mul_q30(mul_q30(sr, sy), sp));
		q.x = round_q15(mul_q30(mul_q30(sr, cy), cp) - mul_q30(mul_q30(cr, sy), sp));
		q.y = round_q15(mul_q30(mul_q30(cr, sy), cp) + mul_q30(mul_q30(sr, cy), sp));
		q.z = round_q15(mul_q30(mul_q30(cr, cy), sp) - mul_q30(mul_q30(sr, sy), cp));
		expected_quats.push_back(q);
	endtask

	task automatic send_angles(input logic signed [15:0] r, input logic signed [15:0] p,
		input logic signed [15:0] yw);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		roll_angle <= r;
		pitch_angle <= p;
		yaw_angle <= yw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_quat(r, p, yw);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 46080) - 23040);
			default: return 16'($urandom_range(0, 512) - 256);
		endcase
	endfunction

	task automatic test_directed();
		logic signed [15:0] corners[12] = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd11520,
			-16'sd11520, 16'sd32767, 16'sh8000, 16'sd1, -16'sd1, 16'sd5760, 16'sd17280,
			-16'sd17280};
		foreach (corners[i])
			send_angles(corners[i], corners[(i + 3) % 12], corners[(i + 7) % 12]);
		send_angles(16'sd32767, 16'sd32767, 16'sd32767);
		send_angles(16'sh8000, 16'sh8000, 16'sh8000);
		send_angles(16'sd11520, 16'sd11520, -16'sd11520);
		send_angles(-16'sd1, 16'sd0, 16'sd23040);
	endtask

	task automatic test_random(input int count);
		repeat (count)
			send_angles(rand_angle(), rand_angle(), rand_angle());
	endtask

	task automatic test_back_to_back(input int count);
		gaps_on = 1'b0;
		repeat (count)
			send_angles(rand_angle(), rand_angle(), rand_angle());
	endtask

	// sink side stalls in bursts until the final part
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		quat_s q;
		if (arst_n && out_valid && out_ready) begin
			if (expected_quats.size() == 0) begin
				$display("%0t: unexpected item w=%0d x=%0d y=%0d z=%0d", $time,
					quat_w, quat_x, quat_y, quat_z);
				errors++;
			end else begin
				q = expected_quats.pop_front();
				if (q.w !== quat_w || q.x !== quat_x || q.y !== quat_y || q.z !== quat_z) begin
					$display("%0t: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
						$time, q.w, q.x, q.y, q.z, quat_w, quat_x, quat_y, quat_z);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		errors = 0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		roll_angle = '0;
		pitch_angle = '0;
		yaw_angle = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(1300);
		test_back_to_back(200);
		in_valid <= 1'b0;
		while (expected_quats.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
